FILE: rtl/llhb_pkg.sv
// llhb_pkg: shared constants for the last-lines history buffer.
// No dependencies; imported by the top level.

package llhb_pkg;

   localparam int BYTE_W      = 8;
   localparam int OFFSET_W    = 4;
   localparam int CHAR_POS_W  = 7;
   localparam int LINE_NUM_W  = 32;
   localparam int LEN_OUT_W   = 7;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_KEEP_W  = 5;

   localparam logic ACTION_APPEND = 1'b0;
   localparam logic ACTION_READ   = 1'b1;

   localparam logic [BYTE_W-1:0]     NEWLINE_BYTE     = 8'd10;
   localparam logic [CSR_KEEP_W-1:0] LINES_KEPT_RESET = 5'd10;

   // register index (paddr[2])
   localparam logic CSR_IDX_LINES_KEPT = 1'b0;

endpackage

FILE: rtl/last_lines_history_buffer.sv
// last_lines_history_buffer: ring of the most recent text lines of a byte stream.
// Depends on llhb_pkg, llhb_ram (byte store) and llhb_len_store (line lengths).
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   action, byte_value, line_offset, char_pos
//   rsp      out        rsp_valid / rsp_stall   line_number, line_present, line_length,
//                                               char_present, char_value
//   csr      in/out     APB psel/penable        lines_kept at byte address 0
//
// One item per cycle while req_stall is low. A read item's result comes from the
// synchronous byte and length memory read and is then registered into the rsp register.
// Appends write byte memory, or length memory for a newline, when accepted; no rsp item.
// Reset is synchronous; the length valid bits clear at once, no clearing pass.
// req_stall rises only while a read result waits behind a stalled rsp register.

module last_lines_history_buffer
   import llhb_pkg::*;
#(
   parameter int MAX_LINES  = 16,
   parameter int LINE_BYTES = 128
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [BYTE_W-1:0]     req_byte_value,
   input  logic [OFFSET_W-1:0]   req_line_offset,
   input  logic [CHAR_POS_W-1:0] req_char_pos,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [LINE_NUM_W-1:0] rsp_line_number,
   output logic                  rsp_line_present,
   output logic [LEN_OUT_W-1:0]  rsp_line_length,
   output logic                  rsp_char_present,
   output logic [BYTE_W-1:0]     rsp_char_value,

   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int SLOT_W      = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int POS_W       = $clog2(LINE_BYTES);
   localparam int KEEP_W      = $clog2(MAX_LINES + 1);
   localparam int SUM_W       = (KEEP_W + 1 > OFFSET_W + 1) ? KEEP_W + 1 : OFFSET_W + 1;
   localparam int STORE_DEPTH = MAX_LINES * (1 << POS_W);
   localparam int STORE_AW    = SLOT_W + POS_W;

   function automatic logic [KEEP_W-1:0] clamp_keep(input logic [CSR_KEEP_W-1:0] v);
      logic [31:0] v32;
      v32 = 32'(v);
      if (v32 == 32'd0) begin
         v32 = 32'd1;
      end else if (v32 > 32'(MAX_LINES)) begin
         v32 = 32'(MAX_LINES);
      end
      return v32[KEEP_W-1:0];
   endfunction

   // restoring remainder, one compare-subtract per slot bit
   function automatic logic [KEEP_W-1:0] slot_mod(input logic [SLOT_W-1:0] ws,
                                                 input logic [KEEP_W-1:0] k);
      logic [31:0] rem;
      logic [31:0] div;
      rem = 32'(ws);
      for (int i = SLOT_W - 1; i >= 0; i--) begin
         div = 32'(k) << i;
         if (rem >= div) begin
            rem = rem - div;
         end
      end
      return rem[KEEP_W-1:0];
   endfunction

   // control state
   logic [CSR_KEEP_W-1:0] kept_ff,       kept_in;
   logic [KEEP_W-1:0]     keff_ff,       keff_in;
   logic [KEEP_W-1:0]     ws_mod_ff,     ws_mod_in;
   logic [SLOT_W-1:0]     ws_ff,         ws_in;
   logic [POS_W-1:0]      wpos_ff,       wpos_in;
   logic [LINE_NUM_W-1:0] seen_ff,       seen_in;
   logic                  s1_valid_ff,   s1_valid_in;
   logic                  rsp_valid_ff,  rsp_valid_in;

   // payload
   logic                  s1_lp_ff;
   logic [LINE_NUM_W-1:0] s1_number_ff;
   logic [CHAR_POS_W-1:0] s1_pos_ff;
   logic [LINE_NUM_W-1:0] rsp_number_ff;
   logic                  rsp_lp_ff;
   logic [LEN_OUT_W-1:0]  rsp_len_ff;
   logic                  rsp_cp_ff;
   logic [BYTE_W-1:0]     rsp_char_ff;

   logic                  req_accept;
   logic                  app_acc;
   logic                  rd_acc;
   logic                  is_nl;
   logic                  byte_we;
   logic                  nl_acc;
   logic                  csr_we;
   logic                  s1_adv;

   logic                  seen_le_k;
   logic [31:0]           off32;
   logic [31:0]           pos32;
   logic [SUM_W-1:0]      sum;
   logic [SUM_W-1:0]      sum_mod;
   logic [31:0]           sum32;
   logic [31:0]           ws_next32;
   logic                  rd_lp;
   logic [SLOT_W-1:0]     rd_slot;
   logic [LINE_NUM_W-1:0] rd_number;
   logic [STORE_AW-1:0]   byte_raddr;
   logic [STORE_AW-1:0]   byte_waddr;

   logic [BYTE_W-1:0]     byte_rdata;
   logic [POS_W-1:0]      len_rdata;
   logic [31:0]           len32;
   logic                  s1_cp;

   assign req_accept = req_valid & ~req_stall;
   assign rd_acc     = req_accept & (req_action == ACTION_READ);
   assign app_acc    = req_accept & (req_action == ACTION_APPEND);
   assign is_nl      = (req_byte_value == NEWLINE_BYTE);
   assign nl_acc     = app_acc & is_nl;
   assign byte_we    = app_acc & ~is_nl & (32'(wpos_ff) < 32'(LINE_BYTES - 1));
   assign csr_we     = psel & penable & pwrite & pready
                       & (paddr[CSR_ADDR_W-1:2] == CSR_IDX_LINES_KEPT);

   assign s1_adv     = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = s1_valid_ff & ~s1_adv;

   // read address and line number
   always_comb begin
      seen_le_k = (seen_ff <= 32'(keff_ff));
      off32     = 32'(req_line_offset);
      pos32     = 32'(req_char_pos);
      sum       = SUM_W'(ws_mod_ff) + SUM_W'(req_line_offset);
      sum_mod   = (sum >= SUM_W'(keff_ff)) ? sum - SUM_W'(keff_ff) : sum;
      sum32     = 32'(sum_mod);
      if (seen_le_k) begin
         rd_lp     = (off32 < seen_ff);
         rd_slot   = off32[SLOT_W-1:0];
         rd_number = off32 + 32'd1;
      end else begin
         rd_lp     = (off32 < 32'(keff_ff));
         rd_slot   = sum32[SLOT_W-1:0];
         rd_number = seen_ff - 32'(keff_ff) + off32 + 32'd1;
      end
      if (!rd_lp) begin
         rd_number = '0;
      end
      byte_raddr = {rd_slot, pos32[POS_W-1:0]};
      byte_waddr = {ws_ff, wpos_ff};
   end

   // write pointer, line counter, configuration
   always_comb begin
      kept_in   = kept_ff;
      keff_in   = keff_ff;
      ws_mod_in = ws_mod_ff;
      ws_in     = ws_ff;
      wpos_in   = wpos_ff;
      seen_in   = seen_ff;
      ws_next32 = 32'(ws_ff) + 32'd1;
      if (nl_acc) begin
         if (ws_next32 >= 32'(keff_ff)) begin
            ws_next32 = 32'd0;
         end
         ws_in     = ws_next32[SLOT_W-1:0];
         ws_mod_in = ws_next32[KEEP_W-1:0];
         wpos_in   = '0;
         if (seen_ff != '1) begin
            seen_in = seen_ff + 32'd1;
         end
      end else if (byte_we) begin
         wpos_in = wpos_ff + POS_W'(1);
      end
      if (csr_we) begin
         kept_in   = pwdata[CSR_KEEP_W-1:0];
         keff_in   = clamp_keep(pwdata[CSR_KEEP_W-1:0]);
         ws_mod_in = slot_mod(ws_ff, clamp_keep(pwdata[CSR_KEEP_W-1:0]));
      end
      s1_valid_in  = rd_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff      <= LINES_KEPT_RESET;
         keff_ff      <= clamp_keep(LINES_KEPT_RESET);
         ws_mod_ff    <= '0;
         ws_ff        <= '0;
         wpos_ff      <= '0;
         seen_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kept_ff      <= kept_in;
         keff_ff      <= keff_in;
         ws_mod_ff    <= ws_mod_in;
         ws_ff        <= ws_in;
         wpos_ff      <= wpos_in;
         seen_ff      <= seen_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   llhb_ram #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (STORE_AW),
      .DATA_W (BYTE_W)
   ) u_byte_store (
      .clock (clock),
      .we    (byte_we),
      .waddr (byte_waddr),
      .wdata (req_byte_value),
      .re    (rd_acc),
      .raddr (byte_raddr),
      .rdata (byte_rdata)
   );

   llhb_len_store #(
      .DEPTH  (MAX_LINES),
      .ADDR_W (SLOT_W),
      .DATA_W (POS_W)
   ) u_len_store (
      .clock (clock),
      .reset (reset),
      .we    (nl_acc),
      .waddr (ws_ff),
      .wdata (wpos_ff),
      .re    (rd_acc),
      .raddr (rd_slot),
      .rdata (len_rdata)
   );

   // stage 1: memory data back, form the result
   assign len32 = 32'(len_rdata);
   assign s1_cp = s1_lp_ff & (32'(s1_pos_ff) < len32);

   always_ff @(posedge clock) begin
      if (rd_acc) begin
         s1_lp_ff     <= rd_lp;
         s1_number_ff <= rd_number;
         s1_pos_ff    <= req_char_pos;
      end
      if (s1_adv) begin
         rsp_number_ff <= s1_number_ff;
         rsp_lp_ff     <= s1_lp_ff;
         rsp_len_ff    <= s1_lp_ff ? len32[LEN_OUT_W-1:0] : '0;
         rsp_cp_ff     <= s1_cp;
         rsp_char_ff   <= s1_cp ? byte_rdata : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_number  = rsp_number_ff;
   assign rsp_line_present = rsp_lp_ff;
   assign rsp_line_length  = rsp_len_ff;
   assign rsp_char_present = rsp_cp_ff;
   assign rsp_char_value   = rsp_char_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_LINES_KEPT) ?
                   CSR_DATA_W'(kept_ff) : '0;

endmodule

FILE: rtl/llhb_ram.sv
// llhb_ram: single-port-write, single-port-read synchronous memory.
// Read data is registered and holds until the next read.

module llhb_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/llhb_len_store.sv
// llhb_len_store: per-slot line length memory with reset-cleared valid bits.
// Depends on llhb_ram; an entry never written reads as zero.

module llhb_len_store #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DEPTH-1:0]  vld_ff;
   logic [DEPTH-1:0]  vld_in;
   logic              rd_vld_ff;
   logic              rd_vld_in;
   logic [DATA_W-1:0] ram_rdata;

   llhb_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (DATA_W)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      vld_in = vld_ff;
      if (we) begin
         vld_in[waddr] = 1'b1;
      end
      rd_vld_in = re ? vld_ff[raddr] : rd_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   assign rdata = rd_vld_ff ? ram_rdata : '0;

endmodule
